// ===== rtl/brs_pkg.sv =====
// shared types and constants for the blocked reachability search
package brs_pkg;

  localparam int unsigned VERTEX_W     = 7;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned MAX_VERTICES = 64;
  localparam logic [VERTEX_W-1:0] COUNT_RESET = 7'd64;

  localparam logic [KIND_W-1:0] KIND_MARK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EDGE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RUN   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

  typedef struct packed {
    logic                clear;
    logic                set_mark;
    logic                mark_val;
    logic                add_edge;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
    logic                start;
    logic                step;
    logic                load_hits;
    logic                shift;
  } cell_cmd_t;

endpackage

// ===== rtl/blocked_reachability_search.sv =====
// top level: control sequencer and row of vertex cells for the blocked reachability search
//
// channel  direction  handshake               payload
// in       in         in_valid_i/in_ready_o   kind_i vertex_a_i vertex_b_i blocking_i
// out      out        out_valid_o/out_ready_i vertex_o found_o last_o
// cfg      in         cfg_valid_i/cfg_ready_o cfg_data_i (vertex_count)
//
// mark, edge and clear beats are taken back to back while no run is in progress
// a run steps the frontier wave across the cells one breadth level at a time,
// then loads the hit bits, then walks the vertex positions up to the highest reported hit
// the hit bits leave through the cell chain one position a cycle; out stalls hold it
// reset clears every cell at once, vertex_count returns to 64
module blocked_reachability_search #(
  parameter int unsigned MAX_VERTICES = brs_pkg::MAX_VERTICES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [brs_pkg::KIND_W-1:0]      kind_i,
  input  logic [brs_pkg::VERTEX_W-1:0]    vertex_a_i,
  input  logic [brs_pkg::VERTEX_W-1:0]    vertex_b_i,
  input  logic                            blocking_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [brs_pkg::VERTEX_W-1:0]    vertex_o,
  output logic                            found_o,
  output logic                            last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [brs_pkg::VERTEX_W-1:0]    cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam logic [brs_pkg::VERTEX_W-1:0] MAX_V = brs_pkg::VERTEX_W'(MAX_VERTICES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } state_e;

  state_e                       state_q;
  logic [brs_pkg::VERTEX_W-1:0] count_q;
  logic [CW-1:0]                cursor_q;
  logic                         out_valid_q;
  logic [brs_pkg::VERTEX_W-1:0] vertex_q;
  logic                         found_q;
  logic                         last_q;

  logic [brs_pkg::VERTEX_W-1:0] n_use;
  logic [MAX_VERTICES-1:0]      in_use;
  logic [MAX_VERTICES-1:0]      expand_vec;
  logic [MAX_VERTICES-1:0]      fr_vec;
  logic [MAX_VERTICES-1:0]      hit_vec;
  logic                         in_beat;
  logic                         a_ok;
  logic                         b_ok;
  logic                         out_free;
  logic                         rest_empty;
  logic                         emit_now;
  brs_pkg::cell_cmd_t           cmd;

  assign n_use      = (count_q > MAX_V) ? MAX_V : count_q;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign a_ok       = (vertex_a_i != '0) && (vertex_a_i <= n_use);
  assign b_ok       = (vertex_b_i != '0) && (vertex_b_i <= n_use);
  assign out_free   = !out_valid_q || out_ready_i;
  assign rest_empty = ~|hit_vec[MAX_VERTICES-1:1];
  assign emit_now   = (state_q == ST_EMIT) && out_free && (hit_vec[0] || ~|hit_vec);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cmd           = '0;
    cmd.vertex_a  = vertex_a_i;
    cmd.vertex_b  = vertex_b_i;
    cmd.mark_val  = blocking_i;
    cmd.set_mark  = in_beat && (kind_i == brs_pkg::KIND_MARK) && a_ok;
    cmd.add_edge  = in_beat && (kind_i == brs_pkg::KIND_EDGE) && a_ok && b_ok;
    cmd.clear     = in_beat && (kind_i == brs_pkg::KIND_CLEAR);
    cmd.start     = in_beat && (kind_i == brs_pkg::KIND_RUN);
    cmd.step      = (state_q == ST_SEARCH) && (|fr_vec);
    cmd.load_hits = (state_q == ST_SEARCH) && !(|fr_vec);
    cmd.shift     = (state_q == ST_EMIT) && out_free;
  end

  for (genvar j = 0; j < MAX_VERTICES; j++) begin : g_cell
    logic hit_next;
    assign in_use[j] = (brs_pkg::VERTEX_W'(j + 1) <= n_use);
    if (j == MAX_VERTICES - 1) begin : g_tail
      assign hit_next = 1'b0;
    end else begin : g_link
      assign hit_next = hit_vec[j+1];
    end
    brs_cell #(
      .MAX_VERTICES (MAX_VERTICES),
      .IDX          (j)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .in_use_i   (in_use[j]),
      .expand_i   (expand_vec),
      .hit_next_i (hit_next),
      .expand_o   (expand_vec[j]),
      .frontier_o (fr_vec[j]),
      .hit_o      (hit_vec[j])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= brs_pkg::COUNT_RESET;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
      vertex_q    <= '0;
      found_q     <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
      if (out_valid_q && out_ready_i && !emit_now) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd.start) begin
            state_q <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (cmd.load_hits) begin
            cursor_q <= CW'(1);
            state_q  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            cursor_q <= cursor_q + CW'(1);
            if (hit_vec[0]) begin
              out_valid_q <= 1'b1;
              vertex_q    <= brs_pkg::VERTEX_W'(cursor_q);
              found_q     <= 1'b1;
              last_q      <= rest_empty;
              if (rest_empty) begin
                state_q <= ST_IDLE;
              end
            end else if (~|hit_vec) begin
              // no marked vertex reached
              out_valid_q <= 1'b1;
              vertex_q    <= '0;
              found_q     <= 1'b0;
              last_q      <= 1'b1;
              state_q     <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign vertex_o    = vertex_q;
  assign found_o     = found_q;
  assign last_o      = last_q;

  a_none_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (last_o && (vertex_o == '0)))
    else $error("no-hit beat must be a final zero beat");

  a_hit_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> ((vertex_o != '0) && (vertex_o <= MAX_V)))
    else $error("reported vertex out of range");

  a_emit_no_frontier : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !(|fr_vec))
    else $error("frontier still live while emitting");

  a_run_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (kind_i == brs_pkg::KIND_RUN)) |=> (state_q == ST_SEARCH))
    else $error("run beat did not start a search");

endmodule

// ===== rtl/brs_cell.sv =====
// one vertex cell: adjacency row, blocking mark, visited and frontier bits, hit shift stage
module brs_cell #(
  parameter int unsigned MAX_VERTICES = brs_pkg::MAX_VERTICES,
  parameter int unsigned IDX          = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  brs_pkg::cell_cmd_t      cmd_i,
  input  logic                    in_use_i,
  input  logic [MAX_VERTICES-1:0] expand_i,
  input  logic                    hit_next_i,
  output logic                    expand_o,
  output logic                    frontier_o,
  output logic                    hit_o
);

  localparam logic [brs_pkg::VERTEX_W-1:0] SELF = brs_pkg::VERTEX_W'(IDX + 1);

  logic [MAX_VERTICES-1:0] row_q, row_d;
  logic                    mark_q, mark_d;
  logic                    vis_q, vis_d;
  logic                    fr_q, fr_d;
  logic                    hit_q, hit_d;
  logic [MAX_VERTICES-1:0] add_bits;
  logic                    reached;

  always_comb begin
    for (int k = 0; k < MAX_VERTICES; k++) begin
      add_bits[k] = ((cmd_i.vertex_a == SELF) &&
                     (cmd_i.vertex_b == brs_pkg::VERTEX_W'(k + 1))) ||
                    ((cmd_i.vertex_b == SELF) &&
                     (cmd_i.vertex_a == brs_pkg::VERTEX_W'(k + 1)));
    end
  end

  assign reached = |(row_q & expand_i);

  always_comb begin
    row_d  = row_q;
    mark_d = mark_q;
    vis_d  = vis_q;
    fr_d   = fr_q;
    hit_d  = hit_q;
    if (cmd_i.clear) begin
      row_d = '0;
      vis_d = 1'b0;
      fr_d  = 1'b0;
    end
    if (cmd_i.add_edge) begin
      row_d = row_q | add_bits;
    end
    if (cmd_i.set_mark && (cmd_i.vertex_a == SELF)) begin
      mark_d = cmd_i.mark_val;
    end
    if (cmd_i.start) begin
      vis_d = 1'b0;
      fr_d  = (IDX == 0) && in_use_i;
    end
    if (cmd_i.step) begin
      vis_d = vis_q | fr_q;
      fr_d  = in_use_i && !(vis_q | fr_q) && reached;
    end
    if (cmd_i.load_hits) begin
      hit_d = vis_q && mark_q && in_use_i;
    end
    if (cmd_i.shift) begin
      hit_d = hit_next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      mark_q <= 1'b0;
      vis_q  <= 1'b0;
      fr_q   <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      row_q  <= row_d;
      mark_q <= mark_d;
      vis_q  <= vis_d;
      fr_q   <= fr_d;
      hit_q  <= hit_d;
    end
  end

  assign expand_o   = fr_q && !mark_q;
  assign frontier_o = fr_q;
  assign hit_o      = hit_q;

endmodule

// ===== dv/brs_checker.sv =====
`timescale 1ns / 100ps
// result checker for the blocked reachability search: mirrors the graph and checks each out beat
module brs_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [brs_pkg::KIND_W-1:0]   kind_i,
  input  logic [brs_pkg::VERTEX_W-1:0] vertex_a_i,
  input  logic [brs_pkg::VERTEX_W-1:0] vertex_b_i,
  input  logic                         blocking_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [brs_pkg::VERTEX_W-1:0] vertex_i,
  input  logic                         found_i,
  input  logic                         last_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [brs_pkg::VERTEX_W-1:0] cfg_data_i,
  output int                           mismatches_o,
  output int                           waiting_o,
  output int                           results_o
);
  import brs_pkg::*;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic                found;
    logic                last;
  } hit_t;

  logic [63:0]         adj_rows [64];
  logic [63:0]         block_marks;
  logic [VERTEX_W-1:0] vertex_count_q;
  hit_t                hit_q [$];

  function automatic int used_count();
    int n;
    n = vertex_count_q;
    return (n > MAX_VERTICES) ? MAX_VERTICES : n;
  endfunction

  function automatic bit in_span(int v, int n);
    return (v >= 1) && (v <= n);
  endfunction

  function automatic void predict_search();
    int          n;
    int          top_hit;
    logic [63:0] span;
    logic [63:0] reached;
    logic [63:0] wave;
    logic [63:0] spread;
    logic [63:0] nxt;
    logic [63:0] hits;
    hit_t        h;
    n = used_count();
    span = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    reached = '0;
    wave = (n >= 1) ? 64'd1 : 64'd0;
    while (wave != '0) begin
      reached |= wave;
      spread = wave & ~block_marks;
      nxt = '0;
      for (int i = 0; i < 64; i++) begin
        if (spread[i]) nxt |= adj_rows[i];
      end
      wave = nxt & span & ~reached;
    end
    hits = reached & block_marks & span;
    top_hit = 0;
    for (int v = 1; v <= n; v++) begin
      if (hits[v-1]) top_hit = v;
    end
    if (top_hit == 0) begin
      h.vertex = '0;
      h.found  = 1'b0;
      h.last   = 1'b1;
      hit_q = {hit_q, h};
    end else begin
      for (int v = 1; v <= top_hit; v++) begin
        if (hits[v-1]) begin
          h.vertex = VERTEX_W'(v);
          h.found  = 1'b1;
          h.last   = (v == top_hit);
          hit_q = {hit_q, h};
        end
      end
    end
  endfunction

  function automatic void apply_beat(logic [KIND_W-1:0] k, int a, int b, logic blk);
    int n;
    n = used_count();
    case (k)
      KIND_MARK: begin
        if (in_span(a, n)) block_marks[a-1] = blk;
      end
      KIND_EDGE: begin
        if (in_span(a, n) && in_span(b, n)) begin
          adj_rows[a-1][b-1] = 1'b1;
          adj_rows[b-1][a-1] = 1'b1;
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < 64; i++) adj_rows[i] = '0;
      end
      default: predict_search();
    endcase
  endfunction

  function automatic void flag_mismatch(hit_t want, bit had_want);
    mismatches_o++;
    if (mismatches_o <= 10) begin
      if (had_want)
        $display("mismatch at result %0d: expected vertex %0d found %0b last %0b, got %0d %0b %0b",
                 results_o, want.vertex, want.found, want.last, vertex_i, found_i, last_i);
      else
        $display("mismatch at result %0d: nothing expected, got vertex %0d found %0b last %0b",
                 results_o, vertex_i, found_i, last_i);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hit_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 64; i++) adj_rows[i] = '0;
      block_marks    = '0;
      vertex_count_q = COUNT_RESET;
      hit_q.delete();
      mismatches_o   = 0;
      waiting_o      = 0;
      results_o      = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (hit_q.size() == 0) begin
          want = '0;
          flag_mismatch(want, 1'b0);
        end else begin
          want = hit_q.pop_front();
          if (vertex_i !== want.vertex || found_i !== want.found || last_i !== want.last)
            flag_mismatch(want, 1'b1);
        end
      end
      if (cfg_valid_i && cfg_ready_i) vertex_count_q = cfg_data_i;
      if (in_valid_i && in_ready_i)
        apply_beat(kind_i, int'(vertex_a_i), int'(vertex_b_i), blocking_i);
      waiting_o = hit_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// testbench top for the blocked reachability search: clock, reset, stimulus and verdict
module tb_top;
  import brs_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 12;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   kind = KIND_MARK;
  logic [VERTEX_W-1:0] vertex_a = '0;
  logic [VERTEX_W-1:0] vertex_b = '0;
  logic                blocking = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [VERTEX_W-1:0] vertex;
  logic                found;
  logic                last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [VERTEX_W-1:0] cfg_data = '0;

  int mismatches;
  int waiting;
  int results;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int beat_count = 0;
  int search_count = 0;
  int setting_count = 0;
  int vc_now = COUNT_RESET;
  int path_cursor = 1;

  blocked_reachability_search dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .kind_i      (kind),
    .vertex_a_i  (vertex_a),
    .vertex_b_i  (vertex_b),
    .blocking_i  (blocking),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .vertex_o    (vertex),
    .found_o     (found),
    .last_o      (last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  brs_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .kind_i       (kind),
    .vertex_a_i   (vertex_a),
    .vertex_b_i   (vertex_b),
    .blocking_i   (blocking),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .vertex_i     (vertex),
    .found_i      (found),
    .last_i       (last),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .waiting_o    (waiting),
    .results_o    (results)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding", quiet_cycles, waiting);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic hold_gap();
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_beat(logic [KIND_W-1:0] k, logic [VERTEX_W-1:0] a,
                           logic [VERTEX_W-1:0] b, logic blk);
    bit took;
    hold_gap();
    in_valid <= 1'b1;
    kind     <= k;
    vertex_a <= a;
    vertex_b <= b;
    blocking <= blk;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    beat_count++;
    if (k == KIND_RUN) search_count++;
  endtask

  // wait for every expected result, then let any load beat still in flight finish
  task automatic settle();
    bit busy;
    in_valid <= 1'b0;
    do begin
      @(negedge clk);
      busy = (waiting != 0);
      @(posedge clk);
    end while (busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [VERTEX_W-1:0] v);
    bit took;
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
    vc_now = v;
    setting_count++;
  endtask

  function automatic logic [VERTEX_W-1:0] pick_vertex(int n);
    if (n == 0) return VERTEX_W'($urandom_range(0, 127));
    if ($urandom_range(0, 99) < 8)
      return $urandom_range(0, 1) ? '0 : VERTEX_W'($urandom_range(n + 1, 127));
    return VERTEX_W'($urandom_range(1, n));
  endfunction

  task automatic random_phase(int items);
    int                  n;
    int                  roll;
    logic [VERTEX_W-1:0] a;
    logic [VERTEX_W-1:0] b;
    n = (vc_now > MAX_VERTICES) ? MAX_VERTICES : vc_now;
    path_cursor = 1;
    if ($urandom_range(0, 1))
      send_beat(KIND_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom), 1'($urandom));
    for (int i = 0; i < items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 22) begin
        send_beat(KIND_MARK, pick_vertex(n), VERTEX_W'($urandom),
                  ($urandom_range(0, 99) < 40));
      end else if (roll < 72) begin
        // grow a tree out of vertex 1 so searches run deep
        if (path_cursor < n && $urandom_range(0, 99) < 60) begin
          a = VERTEX_W'($urandom_range(1, path_cursor));
          b = VERTEX_W'(path_cursor + 1);
          path_cursor++;
        end else begin
          a = pick_vertex(n);
          b = pick_vertex(n);
        end
        if ($urandom_range(0, 1)) send_beat(KIND_EDGE, a, b, 1'($urandom));
        else send_beat(KIND_EDGE, b, a, 1'($urandom));
      end else if (roll < 94) begin
        send_beat(KIND_RUN, VERTEX_W'($urandom), VERTEX_W'($urandom), 1'($urandom));
        if ($urandom_range(0, 99) < 20) settle();
      end else begin
        send_beat(KIND_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom), 1'($urandom));
        path_cursor = 1;
      end
    end
  endtask

  initial begin
    int phase_counts [10];
    phase_counts = '{64, 2, 127, 1, 0, 0, 64, 100, 9, 64};
    phase_counts[4] = $urandom_range(3, 63);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct = 20;
    stall_pct    = 10;
    send_beat(KIND_RUN,   7'd0,   7'd0,   1'b0);
    send_beat(KIND_MARK,  7'd1,   7'd0,   1'b1);
    send_beat(KIND_EDGE,  7'd1,   7'd2,   1'b0);
    send_beat(KIND_RUN,   7'd127, 7'd127, 1'b1);
    send_beat(KIND_MARK,  7'd1,   7'd0,   1'b0);
    send_beat(KIND_EDGE,  7'd2,   7'd3,   1'b0);
    send_beat(KIND_MARK,  7'd3,   7'd0,   1'b1);
    send_beat(KIND_EDGE,  7'd3,   7'd4,   1'b0);
    send_beat(KIND_MARK,  7'd4,   7'd0,   1'b1);
    send_beat(KIND_EDGE,  7'd64,  7'd2,   1'b0);
    send_beat(KIND_MARK,  7'd64,  7'd0,   1'b1);
    send_beat(KIND_EDGE,  7'd5,   7'd5,   1'b0);
    send_beat(KIND_MARK,  7'd0,   7'd0,   1'b1);
    send_beat(KIND_MARK,  7'd127, 7'd0,   1'b1);
    send_beat(KIND_EDGE,  7'd0,   7'd2,   1'b0);
    send_beat(KIND_EDGE,  7'd2,   7'd65,  1'b0);
    send_beat(KIND_EDGE,  7'd127, 7'd1,   1'b0);
    send_beat(KIND_RUN,   7'd0,   7'd0,   1'b0);
    send_beat(KIND_CLEAR, 7'd0,   7'd0,   1'b0);
    send_beat(KIND_RUN,   7'd0,   7'd0,   1'b0);
    write_count(7'd0);
    send_beat(KIND_RUN,   7'd1,   7'd1,   1'b1);
    write_count(7'd127);
    send_beat(KIND_EDGE,  7'd1,   7'd64,  1'b0);
    send_beat(KIND_RUN,   7'd0,   7'd0,   1'b0);
    write_count(7'd3);
    send_beat(KIND_EDGE,  7'd1,   7'd3,   1'b0);
    send_beat(KIND_RUN,   7'd0,   7'd0,   1'b0);

    for (int p = 0; p < 10; p++) begin
      if (p == 9) begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end else begin
        send_gap_pct = $urandom_range(0, 2) * 15;
        stall_pct    = $urandom_range(0, 2) * 6;
      end
      write_count(VERTEX_W'(phase_counts[p]));
      random_phase(25);
    end

    settle();
    $display("checked %0d results from %0d searches over %0d input beats",
             results, search_count, beat_count);
    $display("vertex_count took %0d settings, from zero through values above the maximum",
             setting_count);
    if (waiting != 0) $display("%0d expected results never arrived", waiting);
    if (mismatches == 0 && waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
